// ===== hdl/tbgc_pkg.sv =====
// Shared types, constants and register indexes for the two-button gesture classifier.
package tbgc_pkg;

   localparam int TimeW    = 32;
   localparam int LongW    = 16;
   localparam int MinW     = 10;
   localparam int TapW     = 16;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam int ReqDataW = 40;
   localparam int RspDataW = 8;

   localparam logic [LongW-1:0] LongResetMs = LongW'(5000);
   localparam logic [MinW-1:0]  MinResetMs  = MinW'(30);
   localparam logic [TapW-1:0]  TapResetMs  = TapW'(1000);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_MIN_PRESS  = 2'd1,
      CSR_DOUBLE_TAP = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LongW-1:0] long_press_ms;
      logic [MinW-1:0]  min_press_ms;
      logic [TapW-1:0]  double_tap_ms;
   } cfg_type;

   typedef struct packed {
      logic             held;
      logic             long_done;
      logic [TimeW-1:0] press_time;
   } button_type;

   typedef struct packed {
      logic long_hit;
      logic short_hit;
   } button_event_type;

   typedef struct packed {
      logic             double_tap_enable;
      logic [TimeW-1:0] now_ms;
      logic             button_b_level;
      logic             button_a_level;
   } req_item_type;

   typedef struct packed {
      logic b_short;
      logic a_single_confirmed;
      logic a_double;
      logic a_short;
      logic b_long;
      logic a_long;
   } rsp_item_type;

   typedef struct packed {
      button_type       a;
      button_type       b;
      logic             tap_waiting;
      logic [TimeW-1:0] tap_deadline;
   } state_type;

   function automatic logic deadline_reached(input logic [TimeW-1:0] now,
                                             input logic [TimeW-1:0] when);
      logic [TimeW-1:0] diff;
      diff = now - when;
      return ~diff[TimeW-1];
   endfunction

endpackage

// ===== hdl/tbgc_button.sv =====
// Press, long-press and release tracking for one button.
module tbgc_button
   import tbgc_pkg::*;
(
   input  logic             level,
   input  logic [TimeW-1:0] now_ms,
   input  cfg_type          cfg,
   input  button_type       cur,
   output button_type       nxt,
   output button_event_type evt
);

   logic             press;
   logic             release_edge;
   logic [TimeW-1:0] start;
   logic             done_pre;
   logic [TimeW-1:0] elapsed;
   logic             long_hit;

   always_comb begin
      press        = level & ~cur.held;
      release_edge = ~level & cur.held;
      start        = press ? now_ms : cur.press_time;
      done_pre     = press ? 1'b0 : cur.long_done;
      elapsed      = now_ms - start;
      long_hit     = level & ~done_pre & (elapsed >= TimeW'(cfg.long_press_ms));

      evt.long_hit  = long_hit;
      evt.short_hit = release_edge & ~done_pre & (elapsed >= TimeW'(cfg.min_press_ms));

      nxt.held       = level;
      nxt.long_done  = release_edge ? 1'b0 : (done_pre | long_hit);
      nxt.press_time = start;
   end

endmodule

// ===== hdl/tbgc_classify.sv =====
// Per-poll gesture logic: both button trackers plus the A tap window.
module tbgc_classify
   import tbgc_pkg::*;
(
   input  req_item_type item,
   input  cfg_type      cfg,
   input  state_type    cur,
   output state_type    nxt,
   output rsp_item_type rsp
);

   button_event_type a_evt;
   button_event_type b_evt;
   logic             wait1;
   logic             wait2;
   logic [TimeW-1:0] dl2;
   logic             dbl;
   logic             sgl;

   tbgc_button u_btn_a (
      .level  (item.button_a_level),
      .now_ms (item.now_ms),
      .cfg    (cfg),
      .cur    (cur.a),
      .nxt    (nxt.a),
      .evt    (a_evt)
   );

   tbgc_button u_btn_b (
      .level  (item.button_b_level),
      .now_ms (item.now_ms),
      .cfg    (cfg),
      .cur    (cur.b),
      .nxt    (nxt.b),
      .evt    (b_evt)
   );

   always_comb begin
      wait1 = cur.tap_waiting & ~a_evt.long_hit & ~b_evt.long_hit;
      wait2 = wait1;
      dl2   = cur.tap_deadline;
      dbl   = 1'b0;
      rsp   = '0;
      if (a_evt.short_hit) begin
         if (item.double_tap_enable) begin
            if (wait1 && !deadline_reached(item.now_ms, cur.tap_deadline)) begin
               wait2 = 1'b0;
               dbl   = 1'b1;
            end else begin
               wait2 = 1'b1;
               dl2   = item.now_ms + TimeW'(cfg.double_tap_ms);
            end
         end else begin
            rsp.a_short = 1'b1;
         end
      end
      sgl = wait2 & deadline_reached(item.now_ms, dl2);

      rsp.a_long             = a_evt.long_hit;
      rsp.b_long             = b_evt.long_hit;
      rsp.a_double           = dbl;
      rsp.a_single_confirmed = sgl;
      rsp.b_short            = b_evt.short_hit;

      nxt.tap_waiting  = wait2 & ~sgl;
      nxt.tap_deadline = dl2;
   end

endmodule

// ===== hdl/two_button_gesture_classifier.sv =====
// Top level: input register, gesture state, config registers and result register.
//
// channel | dir | fields (tdata, low bit first)
// req     | in  | button_a_level, button_b_level, now_ms[31:0], double_tap_enable, pad
// rsp     | out | a_long, b_long, a_short, a_double, a_single_confirmed, b_short, pad
// csr     | in  | write enable, register index, write data
//
// req to rsp via input and result registers; one transaction per cycle while rsp is ready.
// The gesture state updates as an item moves from the input register to the result
// register, so consecutive items see each other's effects with no gap.
// A stalled rsp holds the result; req keeps being taken while the input register can drain.
// Synchronous reset clears valids, gesture state and config to defaults.
module two_button_gesture_classifier
   import tbgc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // a_level, b_level, now_ms[31:0], dt_enable
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // a_long, b_long, a_short, a_double, a_single, b_short
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   req_item_type item_ff;
   logic         in_vld_ff;
   rsp_item_type rsp_ff;
   logic         out_vld_ff;
   state_type    state_ff;
   state_type    state_in;
   rsp_item_type rsp_in;
   cfg_type      cfg_ff;
   logic         move;

   assign move       = in_vld_ff & (~out_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | move;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RspDataW'(rsp_ff);

   tbgc_classify u_classify (
      .item (item_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (move) begin
            out_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata[$bits(req_item_type)-1:0];
      end
      if (move) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms <= LongResetMs;
         cfg_ff.min_press_ms  <= MinResetMs;
         cfg_ff.double_tap_ms <= TapResetMs;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_PRESS: cfg_ff.long_press_ms <= csr_wdata[LongW-1:0];
            CSR_MIN_PRESS:  cfg_ff.min_press_ms  <= csr_wdata[MinW-1:0];
            CSR_DOUBLE_TAP: cfg_ff.double_tap_ms <= csr_wdata[TapW-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== test/two_button_gesture_classifier_tb.sv =====
// Testbench for two_button_gesture_classifier: directed and random polls checked against a predictor.
`timescale 1ns / 1ps

module two_button_gesture_classifier_tb
   import tbgc_pkg::*;
;

   localparam logic [CsrIdxW-1:0] CsrSpare = 2'd3;
   localparam int DrainCycles = 4;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_LONG_PRESS;
   logic [CsrDataW-1:0] csr_wdata = '0;

   two_button_gesture_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor copy of settings and gesture state
   logic [LongW-1:0]  long_cfg = LongResetMs;
   logic [MinW-1:0]   min_cfg  = MinResetMs;
   logic [TapW-1:0]   tap_cfg  = TapResetMs;
   logic              a_down = 1'b0, b_down = 1'b0;
   logic              a_long_seen = 1'b0, b_long_seen = 1'b0;
   logic [TimeW-1:0]  a_start = '0, b_start = '0;
   logic              tap_open = 1'b0;
   logic [TimeW-1:0]  tap_due = '0;

   req_item_type pending_polls[$];
   rsp_item_type expected_events[$];
   req_item_type held_item;

   string field_names [6] = '{"a_long", "b_long", "a_short", "a_double",
                              "a_single_confirmed", "b_short"};
   int    event_count [6] = '{0, 0, 0, 0, 0, 0};
   int    error_count = 0;
   int    polls_sent = 0;
   int    results_seen = 0;
   int    cycle_count = 0;
   logic  calm;

   assign calm = (cycle_count % 3000) >= 2200;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic logic due_reached(input logic [TimeW-1:0] now, input logic [TimeW-1:0] due);
      logic [TimeW-1:0] gap;
      gap = now - due;
      return !gap[TimeW-1];
   endfunction

   function automatic rsp_item_type classify_poll(input req_item_type p);
      rsp_item_type     r;
      logic [TimeW-1:0] held_ms;
      r = '0;
      if (p.button_a_level && !a_down) begin
         a_down = 1'b1;
         a_long_seen = 1'b0;
         a_start = p.now_ms;
      end
      if (p.button_b_level && !b_down) begin
         b_down = 1'b1;
         b_long_seen = 1'b0;
         b_start = p.now_ms;
      end
      if (a_down && p.button_a_level && !a_long_seen &&
          (p.now_ms - a_start) >= {16'b0, long_cfg}) begin
         a_long_seen = 1'b1;
         tap_open = 1'b0;
         r.a_long = 1'b1;
      end
      if (b_down && p.button_b_level && !b_long_seen &&
          (p.now_ms - b_start) >= {16'b0, long_cfg}) begin
         b_long_seen = 1'b1;
         tap_open = 1'b0;
         r.b_long = 1'b1;
      end
      if (!p.button_a_level && a_down) begin
         held_ms = p.now_ms - a_start;
         a_down = 1'b0;
         if (!a_long_seen && held_ms >= {22'b0, min_cfg}) begin
            if (p.double_tap_enable) begin
               if (tap_open && !due_reached(p.now_ms, tap_due)) begin
                  tap_open = 1'b0;
                  r.a_double = 1'b1;
               end else begin
                  tap_open = 1'b1;
                  tap_due = p.now_ms + {16'b0, tap_cfg};
               end
            end else begin
               r.a_short = 1'b1;
            end
         end
         a_long_seen = 1'b0;
      end
      if (!p.button_b_level && b_down) begin
         held_ms = p.now_ms - b_start;
         b_down = 1'b0;
         if (!b_long_seen && held_ms >= {22'b0, min_cfg})
            r.b_short = 1'b1;
         b_long_seen = 1'b0;
      end
      if (tap_open && due_reached(p.now_ms, tap_due)) begin
         tap_open = 1'b0;
         r.a_single_confirmed = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_events.size() == 0) begin
         report_mismatch($sformatf("result %b with nothing expected", got));
         return;
      end
      want = expected_events.pop_front();
      results_seen++;
      for (int i = 0; i < 6; i++) begin
         if (want[i])
            event_count[i]++;
         if (got[i] !== want[i])
            report_mismatch($sformatf("result %0d %s got %b want %b",
                                      results_seen, field_names[i], got[i], want[i]));
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_events.push_back(classify_poll(held_item));
            polls_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_polls.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
               held_item = pending_polls.pop_front();
               req_tdata <= {{(ReqDataW - $bits(req_item_type)){1'b0}}, held_item};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tdata[$bits(rsp_item_type)-1:0]);
         rsp_tready <= calm || $urandom_range(0, 99) >= 6;
      end
   end

   function automatic void queue_poll(input logic a, input logic b,
                                      input logic [TimeW-1:0] t, input logic dt);
      req_item_type p;
      p.button_a_level = a;
      p.button_b_level = b;
      p.now_ms = t;
      p.double_tap_enable = dt;
      pending_polls.push_back(p);
   endfunction

   // sampled away from the rising edge so driver updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_polls.size() != 0 || expected_events.size() != 0 || req_tvalid);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CsrDataW-1:0] lp, input logic [CsrDataW-1:0] mp,
                                 input logic [CsrDataW-1:0] tp);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= lp;
      @(posedge clock);
      csr_index <= CSR_MIN_PRESS;
      csr_wdata <= mp;
      @(posedge clock);
      csr_index <= CSR_DOUBLE_TAP;
      csr_wdata <= tp;
      @(posedge clock);
      csr_index <= CsrSpare;
      csr_wdata <= CsrDataW'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      long_cfg = lp;
      min_cfg = mp[MinW-1:0];
      tap_cfg = tp;
   endtask

   // random walk of button levels; steps sized to the current thresholds
   task automatic random_phase(input int n, input logic [TimeW-1:0] base);
      logic             a, b, dt;
      logic [TimeW-1:0] t;
      int unsigned      scale;
      a = 1'b0;
      b = 1'b0;
      dt = 1'($urandom_range(0, 1));
      t = base;
      repeat (n) begin
         if ($urandom_range(0, 99) < 5) begin
            queue_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                       1'($urandom_range(0, 1)));
         end else begin
            case ($urandom_range(0, 2))
               0: scale = min_cfg + 2;
               1: scale = tap_cfg / 2 + 2;
               default: scale = long_cfg / 2 + 2;
            endcase
            t = t + $urandom_range(0, scale);
            if ($urandom_range(0, 99) < 35) a = !a;
            if ($urandom_range(0, 99) < 25) b = !b;
            if ($urandom_range(0, 99) < 6) dt = !dt;
            queue_poll(a, b, t, dt);
         end
      end
   endtask

   initial begin
      logic [CsrDataW-1:0] lp, mp, tp;
      logic [TimeW-1:0]    base;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: 5000 long, 30 min, 1000 window
      queue_poll(1, 0, 32'd0, 0);
      queue_poll(0, 0, 32'd10, 0);            // hold under minimum
      queue_poll(1, 0, 32'd200, 0);
      queue_poll(0, 0, 32'd300, 0);           // a_short
      queue_poll(0, 1, 32'd400, 0);
      queue_poll(0, 0, 32'd500, 0);           // b_short
      queue_poll(1, 0, 32'd1000, 0);
      queue_poll(1, 0, 32'd6000, 0);          // a_long
      queue_poll(0, 0, 32'd6100, 0);          // release after long: nothing
      queue_poll(0, 1, 32'd7000, 1);
      queue_poll(0, 1, 32'd12000, 1);         // b_long
      queue_poll(0, 0, 32'd12100, 1);
      queue_poll(1, 0, 32'd13000, 1);
      queue_poll(0, 0, 32'd13100, 1);         // window opens
      queue_poll(1, 0, 32'd13200, 1);
      queue_poll(0, 0, 32'd13300, 1);         // a_double
      queue_poll(1, 0, 32'd14000, 1);
      queue_poll(0, 0, 32'd14100, 1);
      queue_poll(0, 0, 32'd15100, 1);         // window expires
      queue_poll(1, 1, 32'hFFFF_FFFF, 0);
      queue_poll(0, 0, 32'h0000_0030, 0);     // hold across timestamp wrap

      // zero long press time
      write_settings(16'd0, 16'd0, 16'd1000);
      queue_poll(1, 0, 32'd50, 0);
      queue_poll(0, 1, 32'd60, 0);
      queue_poll(0, 0, 32'd70, 0);
      // zero tap window
      write_settings(16'd5000, 16'd0, 16'd0);
      queue_poll(1, 0, 32'd100, 1);
      queue_poll(0, 0, 32'd100, 1);

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin lp = 16'hFFFF; mp = 16'hFFFF; tp = 16'hFFFF; end
            1: begin lp = 16'd1; mp = 16'hFC00; tp = 16'd1; end
            2: begin lp = {LongW'(LongResetMs)}; mp = {6'h2A, MinResetMs}; tp = TapResetMs; end
            default: begin
               lp = 16'($urandom_range(1, 400));
               mp = {6'($urandom), 10'($urandom_range(0, 60))};
               tp = 16'($urandom_range(1, 500));
            end
         endcase
         write_settings(lp, mp, tp);
         base = (ph == 3) ? 32'hFFFF_F000 : $urandom;
         random_phase(85, base);
      end

      wait_idle();
      $display("polls %0d, results %0d: a_long %0d b_long %0d a_short %0d a_double %0d",
               polls_sent, results_seen, event_count[0], event_count[1], event_count[2],
               event_count[3]);
      $display("a_single_confirmed %0d b_short %0d over 13 settings incl. zero and full-scale",
               event_count[4], event_count[5]);
      if (error_count == 0)
         $display("PASS two_button_gesture_classifier");
      else
         $display("FAIL two_button_gesture_classifier");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", expected_events.size());
      $display("FAIL two_button_gesture_classifier");
      $finish;
   end

endmodule
